/* src/lpmr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed message ring.
// No dependencies; every other file takes names from here by scope.
package lpmr_pkg;

    localparam int RING_BYTES_DEF = 1024;
    localparam int HDR_BYTES      = 4;
    localparam int LEN_W          = 16;
    localparam int LEVEL_W        = 10;
    localparam int CFG_AW         = 3;
    localparam int REG_MAX_PAYLOAD = 0;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd1019;

    // Item kinds as classified by the front end
    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_PUSH_LAST,
        KIND_POP
    } kind_t;

    typedef enum logic [2:0] {
        STAT_TAKEN    = 3'd0,
        STAT_ACCEPTED = 3'd1,
        STAT_REJECTED = 3'd2,
        STAT_DATA     = 3'd3,
        STAT_EMPTY    = 3'd4,
        STAT_CORRUPT  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR_WR,
        BK_HDR_RD,
        BK_HDR_CHK,
        BK_DATA_RD
    } back_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

/* src/length_prefixed_message_ring_unit.sv */
`timescale 1ns / 1ps
// Top level of the length-prefixed message ring: config register, front
// queue and back sequencer. Uses lpmr_pkg, lpmr_front, lpmr_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  s_*      | s_tvalid / s_tready     | s_tuser mode, s_tdata data_in, s_tlast in_last
//  m_*      | m_tvalid / m_tready     | m_tuser status, m_tdata data/fill/free, m_tlast
//  APB      | psel & penable & pwrite | paddr 0: max_payload (16 bits)
//
//  Push byte: written from idle. Committing last byte: 4 header writes follow on the
//  single memory write port. Pop of a message's first byte: 4 header reads plus check
//  and data read; later bytes: a registered read. Empty and reject: answered from idle;
//  corrupt header: reported at the check after the header reads.
//  A two-entry queue takes input while a result waits; the ring is not cleared.
module length_prefixed_message_ring_unit
#(
    parameter int RING_BYTES = lpmr_pkg::RING_BYTES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpmr_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_in
    input  logic                        s_tuser,   // [0] mode
    input  logic                        s_tlast,   // in_last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [7:0] data_out, [17:8] fill_level,
                                                   // [27:18] free_space, [31:28] zero
    output logic [2:0]                  m_tuser,   // [2:0] status
    output logic                        m_tlast    // out_last
);

    localparam int IDX_W = lpmr_pkg::CFG_AW - 2;

    logic [lpmr_pkg::LEN_W-1:0] max_payload_reg;
    logic [IDX_W-1:0]           reg_idx;
    logic                       cfg_wr;
    lpmr_pkg::queue_head_t      head;
    logic                       take;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lpmr_pkg::CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == IDX_W'(lpmr_pkg::REG_MAX_PAYLOAD)) ?
                     32'(max_payload_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= lpmr_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_wr && reg_idx == IDX_W'(lpmr_pkg::REG_MAX_PAYLOAD))
        begin
            max_payload_reg <= pwdata[lpmr_pkg::LEN_W-1:0];
        end
    end

    lpmr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .head     (head),
        .take     (take)
    );

    lpmr_back
    #(
        .RING_BYTES (RING_BYTES)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .take        (take),
        .max_payload (max_payload_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

/* src/lpmr_front.sv */
`timescale 1ns / 1ps
// Front end: accepts stream items, classifies them and holds them in a
// two-entry queue for the back end. Uses lpmr_pkg.
module lpmr_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_in
    input  logic                s_tuser,   // [0] mode
    input  logic                s_tlast,
    output lpmr_pkg::queue_head_t head,
    input  logic                take
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    lpmr_pkg::item_t    q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    lpmr_pkg::item_t    item_in;
    logic               push;

    always_comb
    begin
        item_in.data = s_tdata;
        if (s_tuser)
            item_in.kind = lpmr_pkg::KIND_POP;
        else if (s_tlast)
            item_in.kind = lpmr_pkg::KIND_PUSH_LAST;
        else
            item_in.kind = lpmr_pkg::KIND_PUSH;
    end

    assign s_tready   = (cnt_reg != QCNT_W'(QDEPTH));
    assign push       = s_tvalid && s_tready;
    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

    a_take_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (cnt_reg != '0))
        else $error("queue taken while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

/* src/lpmr_back.sv */
`timescale 1ns / 1ps
// Back end: ring memory, push/pop sequencer and the output register.
// Uses lpmr_pkg; fed by lpmr_front through a queue_head_t.
module lpmr_back
#(
    parameter int RING_BYTES = lpmr_pkg::RING_BYTES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lpmr_pkg::queue_head_t        head,
    output logic                         take,
    input  logic [lpmr_pkg::LEN_W-1:0]   max_payload,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [7:0] data_out, [17:8] fill_level,
                                                    // [27:18] free_space, [31:28] zero
    output logic [2:0]                   m_tuser,   // [2:0] status
    output logic                         m_tlast    // out_last
);

    localparam int PTR_W   = $clog2(RING_BYTES);
    localparam int CNT_W   = PTR_W + 1;
    localparam int LEN_W   = lpmr_pkg::LEN_W;
    localparam int LEVEL_W = lpmr_pkg::LEVEL_W;
    localparam int HDR     = lpmr_pkg::HDR_BYTES;
    localparam logic [CNT_W-1:0] RING_V = CNT_W'(RING_BYTES);

    // base + off, folded back into the ring; off stays below the ring size
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(RING_V))
            sum = sum - (CNT_W+1)'(RING_V);
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] c,
                                                  input logic [PTR_W-1:0] r);
        logic [CNT_W-1:0] a;
        a = CNT_W'(c) - CNT_W'(r);
        if (c < r)
            a = a + RING_V;
        return a[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_free(input logic [PTR_W-1:0] c,
                                                  input logic [PTR_W-1:0] r);
        logic [CNT_W-1:0] a;
        a = CNT_W'(r) - CNT_W'(c) - CNT_W'(1);
        if (r <= c)
            a = a + RING_V;
        return a[PTR_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] to_level(input logic [PTR_W-1:0] v);
        logic [PTR_W+LEVEL_W-1:0] w;
        w = (PTR_W+LEVEL_W)'(v);
        return w[LEVEL_W-1:0];
    endfunction

    logic [7:0]               ring_mem [RING_BYTES];
    logic [7:0]               rdata_reg;

    lpmr_pkg::back_state_t    state_reg, state_next;
    logic [1:0]               idx_reg, idx_next;
    logic [23:0]              hdr_reg, hdr_next;
    logic [PTR_W-1:0]         read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0]         commit_ptr_reg, commit_ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     pop_active_reg, pop_active_next;
    logic [LEN_W-1:0]         pop_len_reg, pop_len_next;
    logic [LEN_W-1:0]         pop_off_reg, pop_off_next;
    logic [CNT_W-1:0]         hdr_len_reg, hdr_len_next;
    logic [PTR_W-1:0]         commit_new_reg, commit_new_next;
    logic [PTR_W-1:0]         read_new_reg, read_new_next;
    logic [PTR_W-1:0]         fill_reg, fill_next;
    logic [PTR_W-1:0]         free_reg, free_next;

    logic                     m_valid_reg;
    lpmr_pkg::status_t        status_out_reg;
    logic [7:0]               dout_reg;
    logic                     olast_reg;
    logic [LEVEL_W-1:0]       fill_out_reg;
    logic [LEVEL_W-1:0]       free_out_reg;

    logic                     we;
    logic [PTR_W-1:0]         waddr;
    logic [7:0]               wdata;
    logic [PTR_W-1:0]         raddr;

    logic                     emit;
    lpmr_pkg::status_t        emit_status;
    logic [7:0]               emit_dout;
    logic                     emit_last;
    logic [PTR_W-1:0]         emit_fill;
    logic [PTR_W-1:0]         emit_free;

    logic                     out_free;
    logic [CNT_W:0]           need;
    logic                     fits;
    logic [CNT_W-1:0]         off_push;
    logic [31:0]              hdr_full;
    logic [31:0]              hdr_word;
    logic                     corrupt;
    logic                     pop_done;

    assign out_free = !m_valid_reg || m_tready;
    assign off_push = CNT_W'(HDR) + count_reg;
    assign need     = (CNT_W+1)'(count_reg) + (CNT_W+1)'(HDR + 1);
    assign fits     = !ovf_reg && (need <= (CNT_W+1)'(free_reg));
    assign hdr_full = {hdr_reg, rdata_reg};
    assign hdr_word = 32'(hdr_len_reg);
    assign corrupt  = (hdr_full == '0) || (hdr_full[31:LEN_W] != '0) ||
                      (hdr_full[LEN_W-1:0] > max_payload);
    assign pop_done = ((LEN_W+1)'(pop_off_reg) + (LEN_W+1)'(1)) >= (LEN_W+1)'(pop_len_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hdr_next        = hdr_reg;
        read_ptr_next   = read_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pop_active_next = pop_active_reg;
        pop_len_next    = pop_len_reg;
        pop_off_next    = pop_off_reg;
        hdr_len_next    = hdr_len_reg;
        commit_new_next = commit_new_reg;
        read_new_next   = read_new_reg;
        fill_next       = fill_reg;
        free_next       = free_reg;

        take  = 1'b0;
        we    = 1'b0;
        waddr = commit_ptr_reg;
        wdata = head.item.data;
        raddr = read_ptr_reg;

        emit        = 1'b0;
        emit_status = lpmr_pkg::STAT_TAKEN;
        emit_dout   = 8'd0;
        emit_last   = 1'b0;
        emit_fill   = fill_reg;
        emit_free   = free_reg;

        case (state_reg)
            lpmr_pkg::BK_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    take = 1'b1;
                    case (head.item.kind)
                        lpmr_pkg::KIND_PUSH, lpmr_pkg::KIND_PUSH_LAST:
                        begin
                            if (fits)
                            begin
                                we         = 1'b1;
                                waddr      = wrap_add(commit_ptr_reg, off_push);
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            if (head.item.kind == lpmr_pkg::KIND_PUSH)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                count_next = '0;
                                ovf_next   = 1'b0;
                                if (!fits)
                                begin
                                    emit        = 1'b1;
                                    emit_status = lpmr_pkg::STAT_REJECTED;
                                end
                                else
                                begin
                                    // header goes into the reserved slot next
                                    hdr_len_next    = count_reg + CNT_W'(1);
                                    commit_new_next = wrap_add(commit_ptr_reg,
                                                               off_push + CNT_W'(1));
                                    idx_next        = '0;
                                    state_next      = lpmr_pkg::BK_HDR_WR;
                                end
                            end
                        end
                        lpmr_pkg::KIND_POP:
                        begin
                            if (pop_active_reg)
                            begin
                                raddr = wrap_add(read_ptr_reg,
                                                 CNT_W'(HDR) + CNT_W'(pop_off_reg));
                                state_next = lpmr_pkg::BK_DATA_RD;
                            end
                            else if (read_ptr_reg == commit_ptr_reg)
                            begin
                                emit        = 1'b1;
                                emit_status = lpmr_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                raddr      = read_ptr_reg;
                                idx_next   = 2'd1;
                                state_next = lpmr_pkg::BK_HDR_RD;
                            end
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end

            lpmr_pkg::BK_HDR_WR:
            begin
                // big-endian: byte 0 carries bits 31:24
                we       = 1'b1;
                waddr    = wrap_add(commit_ptr_reg, CNT_W'(idx_reg));
                wdata    = 8'(hdr_word >> {~idx_reg, 3'b000});
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'(HDR - 1))
                begin
                    commit_ptr_next = commit_new_reg;
                    emit            = 1'b1;
                    emit_status     = lpmr_pkg::STAT_ACCEPTED;
                    emit_fill       = ring_fill(commit_new_reg, read_ptr_reg);
                    emit_free       = ring_free(commit_new_reg, read_ptr_reg);
                    fill_next       = emit_fill;
                    free_next       = emit_free;
                    state_next      = lpmr_pkg::BK_IDLE;
                end
            end

            lpmr_pkg::BK_HDR_RD:
            begin
                raddr    = wrap_add(read_ptr_reg, CNT_W'(idx_reg));
                hdr_next = {hdr_reg[15:0], rdata_reg};
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'(HDR - 1))
                begin
                    state_next = lpmr_pkg::BK_HDR_CHK;
                end
            end

            lpmr_pkg::BK_HDR_CHK:
            begin
                if (corrupt)
                begin
                    // leave head in place
                    emit        = 1'b1;
                    emit_status = lpmr_pkg::STAT_CORRUPT;
                    state_next  = lpmr_pkg::BK_IDLE;
                end
                else
                begin
                    pop_active_next = 1'b1;
                    pop_len_next    = hdr_full[LEN_W-1:0];
                    pop_off_next    = '0;
                    read_new_next   = wrap_add(read_ptr_reg,
                                               CNT_W'(HDR) + CNT_W'(hdr_full[LEN_W-1:0]));
                    raddr           = wrap_add(read_ptr_reg, CNT_W'(HDR));
                    state_next      = lpmr_pkg::BK_DATA_RD;
                end
            end

            lpmr_pkg::BK_DATA_RD:
            begin
                pop_off_next = pop_off_reg + LEN_W'(1);
                emit         = 1'b1;
                emit_status  = lpmr_pkg::STAT_DATA;
                emit_dout    = rdata_reg;
                if (pop_done)
                begin
                    // release the whole message
                    emit_last       = 1'b1;
                    read_ptr_next   = read_new_reg;
                    pop_active_next = 1'b0;
                    pop_off_next    = '0;
                    pop_len_next    = '0;
                    emit_fill       = ring_fill(commit_ptr_reg, read_new_reg);
                    emit_free       = ring_free(commit_ptr_reg, read_new_reg);
                    fill_next       = emit_fill;
                    free_next       = emit_free;
                end
                state_next = lpmr_pkg::BK_IDLE;
            end

            default:
            begin
                state_next = lpmr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lpmr_pkg::BK_IDLE;
            idx_reg        <= '0;
            read_ptr_reg   <= '0;
            commit_ptr_reg <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pop_active_reg <= 1'b0;
            pop_len_reg    <= '0;
            pop_off_reg    <= '0;
            fill_reg       <= '0;
            free_reg       <= PTR_W'(RING_BYTES - 1);
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            read_ptr_reg   <= read_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pop_active_reg <= pop_active_next;
            pop_len_reg    <= pop_len_next;
            pop_off_reg    <= pop_off_next;
            fill_reg       <= fill_next;
            free_reg       <= free_next;
            if (emit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg        <= hdr_next;
        hdr_len_reg    <= hdr_len_next;
        commit_new_reg <= commit_new_next;
        read_new_reg   <= read_new_next;
        if (emit)
        begin
            status_out_reg <= emit_status;
            dout_reg       <= emit_dout;
            olast_reg      <= emit_last;
            fill_out_reg   <= to_level(emit_fill);
            free_out_reg   <= to_level(emit_free);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= wdata;
        end
        rdata_reg <= ring_mem[raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_out_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {4'd0, free_out_reg, fill_out_reg, dout_reg};

    a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(fill_reg) + CNT_W'(free_reg)) == CNT_W'(RING_BYTES - 1))
        else $error("fill and free space out of step");

    a_pop_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        pop_active_reg |-> (pop_len_reg != '0 && pop_off_reg < pop_len_reg))
        else $error("pop offset outside message");

    a_commit_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpmr_pkg::BK_HDR_WR && idx_reg == 2'(HDR - 1))
            |=> (m_valid_reg && status_out_reg == lpmr_pkg::STAT_ACCEPTED))
        else $error("header write finished without accept result");

endmodule
